// ----- rtl/core/shw_pkg.sv -----
package shw_pkg;

	localparam int COORD_W       = 16;
	localparam int RAT_W         = 17;
	localparam int U_W           = 31;
	localparam int Q_W           = 32;
	localparam int RECIP_W       = 30;
	localparam int EST_W         = 30;
	localparam int SERIES_K_W    = 8;
	localparam int SERIES_N      = 6;
	localparam int WEIGHT_W      = 17;
	localparam int FRAC_BITS_DEF = 16;
	localparam int S_TDATA_W     = 64;
	localparam int S_TUSER_W     = 2;
	localparam int M_TDATA_W     = 24;

	localparam logic [U_W-1:0]      PI_HALF_Q30 = 31'd1686629713;
	localparam logic [U_W-1:0]      Q30_ONE     = 31'h4000_0000;
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE  = 17'h1_0000;

	typedef struct packed {
		logic valid;
		logic in_range;
		logic force_one;
	} ctl_t;

	// divisors of the nested sine series, innermost term first
	function automatic logic [SERIES_K_W-1:0] series_k(input int idx);
		logic [SERIES_K_W-1:0] k;
		unique case (idx)
			0:       k = 8'd156;
			1:       k = 8'd110;
			2:       k = 8'd72;
			3:       k = 8'd42;
			4:       k = 8'd20;
			5:       k = 8'd6;
			default: k = 8'd6;
		endcase
		return k;
	endfunction

	// floor(2^32 / k) for each series divisor
	function automatic logic [RECIP_W-1:0] series_recip(input int idx);
		logic [RECIP_W-1:0] m;
		unique case (idx)
			0:       m = 30'd27531841;
			1:       m = 30'd39045157;
			2:       m = 30'd59652323;
			3:       m = 30'd102261126;
			4:       m = 30'd214748364;
			5:       m = 30'd715827882;
			default: m = 30'd715827882;
		endcase
		return m;
	endfunction

endpackage

// ----- rtl/core/split_hann_window_weight_core.sv -----
// split Hann blend-window weight for one position along one patch axis
// slave stream: one transaction per position; tdata carries the patch bounds,
// box center and position, tuser the two extend flags
// master stream: one transaction per accepted input, in order; tdata carries
// the Q1.16 weight (65536 is 1.0), tuser the in_range flag
// throughput: one transaction per cycle while the receiver keeps tready high
// pipeline: an operand stage, then the restoring divider takes one stage per
// quotient bit and each of the six series terms takes a multiply, a
// reciprocal multiply and a correction stage
// reset: all valid bits clear, so no transaction is presented after reset
// stall: the output register holds its result and a one-entry skid register
// takes the next; s_axis_tready drops only while the skid register is full,
// and the whole pipeline then freezes with nothing lost or repeated
module split_hann_window_weight_core #(
	parameter int FRAC_BITS = shw_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// span_lo, span_hi, anchor, position
	input  logic [shw_pkg::S_TDATA_W-1:0]   s_axis_tdata,
	// flat_lo, flat_hi
	input  logic [shw_pkg::S_TUSER_W-1:0]   s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// weight, zero pad
	output logic [shw_pkg::M_TDATA_W-1:0]   m_axis_tdata,
	// in_range
	output logic                            m_axis_tuser
);

	localparam int COORD_W = shw_pkg::COORD_W;
	localparam int PAD_W   = shw_pkg::M_TDATA_W - shw_pkg::WEIGHT_W;

	logic                          en;
	logic [FRAC_BITS:0]            ratio;
	shw_pkg::ctl_t                 ratio_ctl, weight_ctl;
	logic [shw_pkg::WEIGHT_W-1:0]  weight, out_weight;
	logic                          out_in_range;

	shw_ratio_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (s_axis_tvalid),
		.span_lo    (s_axis_tdata[0*COORD_W +: COORD_W]),
		.span_hi    (s_axis_tdata[1*COORD_W +: COORD_W]),
		.anchor     (s_axis_tdata[2*COORD_W +: COORD_W]),
		.flat_lo    (s_axis_tuser[0]),
		.flat_hi    (s_axis_tuser[1]),
		.position   (s_axis_tdata[3*COORD_W +: COORD_W]),
		.ratio      (ratio),
		.ratio_ctl  (ratio_ctl)
	);

	shw_sine_sq #(
		.FRAC_BITS(FRAC_BITS)
	) u_sine (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.ratio     (ratio),
		.ratio_ctl (ratio_ctl),
		.weight    (weight),
		.weight_ctl(weight_ctl)
	);

	shw_out_skid u_skid (
		.clk         (clk),
		.arst_n      (arst_n),
		.pipe_ctl    (weight_ctl),
		.pipe_weight (weight),
		.pipe_en     (en),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_weight  (out_weight),
		.out_in_range(out_in_range)
	);

	assign s_axis_tready = en;
	assign m_axis_tdata  = {{PAD_W{1'b0}}, out_weight};
	assign m_axis_tuser  = out_in_range;

	a_zero_outside: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (out_weight == '0))
		else $error("weight nonzero for out-of-range transaction");

	a_weight_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (out_weight <= shw_pkg::WEIGHT_ONE))
		else $error("weight above one");

	a_stall_has_output: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with no result waiting");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
		else $error("skid register filled without an output stall");

endmodule

// ----- rtl/core/shw_ratio_div.sv -----
module shw_ratio_div #(
	parameter int FRAC_BITS = shw_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               in_valid,
	input  logic [shw_pkg::COORD_W-1:0]        span_lo,
	input  logic [shw_pkg::COORD_W-1:0]        span_hi,
	input  logic [shw_pkg::COORD_W-1:0]        anchor,
	input  logic                               flat_lo,
	input  logic                               flat_hi,
	input  logic [shw_pkg::COORD_W-1:0]        position,
	output logic [FRAC_BITS:0]                 ratio,
	output shw_pkg::ctl_t                      ratio_ctl
);

	localparam int RAT_W = shw_pkg::RAT_W;

	logic [shw_pkg::COORD_W-1:0] span, c_off, h_off;
	logic                        bad_bounds, outside, low_side, in_range;
	logic [RAT_W-1:0]            num, den;

	logic [RAT_W-1:0]    rem_s [0:FRAC_BITS];
	logic [RAT_W-1:0]    den_s [0:FRAC_BITS];
	logic [FRAC_BITS:0]  quo_s [0:FRAC_BITS+1];
	shw_pkg::ctl_t       ctl_s [0:FRAC_BITS+1];

	// operand setup
	always_comb begin
		bad_bounds = (anchor < span_lo) || (anchor > span_hi) ||
			(span_hi <= span_lo);
		span       = span_hi - span_lo;
		outside    = position >= span;
		in_range   = !bad_bounds && !outside;
		c_off      = anchor - span_lo;
		h_off      = span_hi - anchor;
		low_side   = position < c_off;
		if (!in_range) begin
			num = '0;
			den = RAT_W'(1);
		end else if (low_side) begin
			num = RAT_W'(position) + RAT_W'(1);
			den = RAT_W'(c_off) + RAT_W'(1);
		end else begin
			num = RAT_W'(span - position);
			den = RAT_W'(h_off);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else if (en) begin
			ctl_s[0].valid     <= in_valid;
			ctl_s[0].in_range  <= in_range;
			ctl_s[0].force_one <= low_side ? flat_lo : flat_hi;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			den_s[0] <= den;
			quo_s[0] <= '0;
		end
	end

	// restoring division, one quotient bit per stage
	for (genvar j = 0; j <= FRAC_BITS; j++) begin : g_step
		logic [RAT_W:0] trial, diff;
		logic           ge;

		always_comb begin
			trial = (j == 0) ? {1'b0, rem_s[j]} : {rem_s[j], 1'b0};
			ge    = trial >= {1'b0, den_s[j]};
			diff  = trial - {1'b0, den_s[j]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[j+1] <= '0;
			end else if (en) begin
				ctl_s[j+1] <= ctl_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[j+1] <= {quo_s[j][FRAC_BITS-1:0], ge};
			end
		end

		if (j < FRAC_BITS) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[j+1] <= ge ? diff[RAT_W-1:0] : trial[RAT_W-1:0];
					den_s[j+1] <= den_s[j];
				end
			end
		end
	end

	assign ratio     = quo_s[FRAC_BITS+1];
	assign ratio_ctl = ctl_s[FRAC_BITS+1];

endmodule

// ----- rtl/core/shw_sine_sq.sv -----
module shw_sine_sq #(
	parameter int FRAC_BITS = shw_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic [FRAC_BITS:0]                 ratio,
	input  shw_pkg::ctl_t                      ratio_ctl,
	output logic [shw_pkg::WEIGHT_W-1:0]       weight,
	output shw_pkg::ctl_t                      weight_ctl
);

	localparam int U_W      = shw_pkg::U_W;
	localparam int Q_W      = shw_pkg::Q_W;
	localparam int EST_W    = shw_pkg::EST_W;
	localparam int RECIP_W  = shw_pkg::RECIP_W;
	localparam int SERIES_N = shw_pkg::SERIES_N;
	localparam int WEIGHT_W = shw_pkg::WEIGHT_W;
	localparam int PROD_W   = FRAC_BITS + 1 + U_W;
	localparam int SQ_W     = 2 * U_W;
	localparam int RND_W    = SQ_W + 1;
	localparam int WQ_W     = RND_W - 44;

	typedef struct packed {
		logic [Q_W-1:0] q;
		logic [U_W-1:0] u;
	} qu_t;

	logic [PROD_W-1:0]   tu;
	logic [SQ_W-1:0]     uu;
	logic [U_W-1:0]      u_s1, u_s2;
	logic [Q_W-1:0]      q_s2;
	shw_pkg::ctl_t       ctl_s1, ctl_s2;

	qu_t                 ser_qu_s [0:SERIES_N];
	logic [U_W-1:0]      ser_r_s  [0:SERIES_N];
	shw_pkg::ctl_t       ser_ctl_s[0:SERIES_N];

	logic [SQ_W-1:0]     us;
	logic [Q_W-1:0]      s_raw;
	logic [U_W-1:0]      sin_s21;
	logic [SQ_W-1:0]     sq_s22;
	logic [RND_W-1:0]    rnd;
	logic [WQ_W-1:0]     wq;
	logic [WEIGHT_W-1:0] w_sat;
	logic [WEIGHT_W-1:0] weight_s23;
	shw_pkg::ctl_t       ctl_s21, ctl_s22, ctl_s23;

	// angle u = t * pi/2 in Q30, then q = u^2
	assign tu = PROD_W'(ratio) * PROD_W'(shw_pkg::PI_HALF_Q30);
	assign uu = SQ_W'(u_s1) * SQ_W'(u_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s1 <= ratio_ctl;
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1 <= tu[FRAC_BITS +: U_W];
			u_s2 <= u_s1;
			q_s2 <= uu[30 +: Q_W];
		end
	end

	assign ser_qu_s[0]  = '{q: q_s2, u: u_s2};
	assign ser_r_s[0]   = shw_pkg::Q30_ONE;
	assign ser_ctl_s[0] = ctl_s2;

	// nested series r = 1 - q*r/k, three stages per term
	for (genvar i = 0; i < SERIES_N; i++) begin : g_term
		localparam logic [shw_pkg::SERIES_K_W-1:0] K = shw_pkg::series_k(i);
		localparam logic [RECIP_W-1:0]             M = shw_pkg::series_recip(i);

		logic [Q_W+U_W-1:0]     qr;
		logic [Q_W+RECIP_W-1:0] xm;
		logic [Q_W-1:0]         kp, rem, d;
		logic                   bump;
		logic [U_W-1:0]         r_next;

		logic [Q_W-1:0]   x_s1, x_s2;
		logic [EST_W-1:0] est_s2;
		qu_t              qu_s1, qu_s2;
		shw_pkg::ctl_t    ctl_s1, ctl_s2;

		assign qr = (Q_W + U_W)'(ser_qu_s[i].q) * (Q_W + U_W)'(ser_r_s[i]);
		assign xm = (Q_W + RECIP_W)'(x_s1) * (Q_W + RECIP_W)'(M);

		always_comb begin
			kp     = Q_W'(est_s2) * Q_W'(K);
			rem    = x_s2 - kp;
			bump   = rem >= Q_W'(K);
			d      = Q_W'(est_s2) + Q_W'(bump);
			r_next = (d >= Q_W'(shw_pkg::Q30_ONE)) ? '0 :
				U_W'(Q_W'(shw_pkg::Q30_ONE) - d);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s1         <= '0;
				ctl_s2         <= '0;
				ser_ctl_s[i+1] <= '0;
			end else if (en) begin
				ctl_s1         <= ser_ctl_s[i];
				ctl_s2         <= ctl_s1;
				ser_ctl_s[i+1] <= ctl_s2;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s1          <= qr[30 +: Q_W];
				qu_s1         <= ser_qu_s[i];
				x_s2          <= x_s1;
				est_s2        <= xm[Q_W +: EST_W];
				qu_s2         <= qu_s1;
				ser_qu_s[i+1] <= qu_s2;
				ser_r_s[i+1]  <= r_next;
			end
		end
	end

	// s = u * r, clamped to one, then squared and rounded to Q1.16; zero out of range, one when forced flat
	always_comb begin
		us    = SQ_W'(ser_qu_s[SERIES_N].u) * SQ_W'(ser_r_s[SERIES_N]);
		s_raw = us[30 +: Q_W];
		rnd   = RND_W'(sq_s22) + (RND_W'(1) << 43);
		wq    = rnd[44 +: WQ_W];
		w_sat = (wq > WQ_W'(shw_pkg::WEIGHT_ONE)) ? shw_pkg::WEIGHT_ONE :
			WEIGHT_W'(wq);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s21 <= '0;
			ctl_s22 <= '0;
			ctl_s23 <= '0;
		end else if (en) begin
			ctl_s21 <= ser_ctl_s[SERIES_N];
			ctl_s22 <= ctl_s21;
			ctl_s23 <= ctl_s22;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sin_s21 <= (s_raw > Q_W'(shw_pkg::Q30_ONE)) ? shw_pkg::Q30_ONE : s_raw[U_W-1:0];
			sq_s22  <= SQ_W'(sin_s21) * SQ_W'(sin_s21);
			if (!ctl_s22.in_range) begin
				weight_s23 <= '0;
			end else if (ctl_s22.force_one) begin
				weight_s23 <= shw_pkg::WEIGHT_ONE;
			end else begin
				weight_s23 <= w_sat;
			end
		end
	end

	assign weight     = weight_s23;
	assign weight_ctl = ctl_s23;

endmodule

// ----- rtl/core/shw_out_skid.sv -----
module shw_out_skid (
	input  logic                          clk,
	input  logic                          arst_n,
	input  shw_pkg::ctl_t                 pipe_ctl,
	input  logic [shw_pkg::WEIGHT_W-1:0]  pipe_weight,
	output logic                          pipe_en,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [shw_pkg::WEIGHT_W-1:0]  out_weight,
	output logic                          out_in_range
);

	logic                          out_v_q, skid_v_q;
	logic [shw_pkg::WEIGHT_W-1:0]  out_weight_q, skid_weight_q;
	logic                          out_range_q, skid_range_q;
	logic                          load_out;

	assign pipe_en  = !skid_v_q;
	assign load_out = out_ready || !out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (load_out) begin
			out_v_q  <= skid_v_q || pipe_ctl.valid;
			skid_v_q <= 1'b0;
		end else if (pipe_ctl.valid) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_weight_q <= skid_v_q ? skid_weight_q : pipe_weight;
			out_range_q  <= skid_v_q ? skid_range_q : pipe_ctl.in_range;
		end else if (pipe_ctl.valid && !skid_v_q) begin
			skid_weight_q <= pipe_weight;
			skid_range_q  <= pipe_ctl.in_range;
		end
	end

	assign out_valid    = out_v_q;
	assign out_weight   = out_weight_q;
	assign out_in_range = out_range_q;

endmodule

// ----- test/tb_split_hann_window_weight_core.sv -----
module tb_split_hann_window_weight_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          FRAC        = shw_pkg::FRAC_BITS_DEF;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30     = 64'h4000_0000;
	localparam logic [16:0] UNITY       = 17'h1_0000;
	localparam int          PAD_W       = shw_pkg::M_TDATA_W - shw_pkg::WEIGHT_W;
	localparam int          MAX_REPORTS = 100;

	typedef struct packed {
		logic [15:0] span_lo;
		logic [15:0] span_hi;
		logic [15:0] anchor;
		logic        flat_lo;
		logic        flat_hi;
		logic [15:0] position;
	} window_req_t;

	typedef struct packed {
		logic [16:0] weight;
		logic        in_range;
	} window_weight_t;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	logic                          clk;
	logic                          arst_n;
	logic                          s_axis_tvalid;
	logic                          s_axis_tready;
	logic [shw_pkg::S_TDATA_W-1:0] s_axis_tdata;
	logic [shw_pkg::S_TUSER_W-1:0] s_axis_tuser;
	logic                          m_axis_tvalid;
	logic                          m_axis_tready;
	logic [shw_pkg::M_TDATA_W-1:0] m_axis_tdata;
	logic                          m_axis_tuser;

	window_req_t    window_reqs[$];
	window_weight_t expected_weights[$];
	int unsigned    accepted_in;
	int unsigned    n_items;
	int unsigned    errors;
	bit             in_taken;
	int unsigned    gap_left;
	int unsigned    burst_left;
	int unsigned    rx_cycle;
	int unsigned    hold_left;
	bit             hold_done;
	rx_mode_t       rx_mode;

	split_hann_window_weight_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// sin^2(pi/2 * t) in Q1.16 from a 16-bit fraction, nested series for the sine
	function automatic logic [16:0] sin_sq_q16(input logic [63:0] t);
		logic [63:0] u;
		logic [63:0] q;
		logic [63:0] r;
		logic [63:0] d;
		logic [63:0] s;
		logic [63:0] w;
		logic [63:0] dv;
		u = (t * HALF_PI_Q30) >> FRAC;
		q = (u * u) >> 30;
		r = ONE_Q30;
		for (int k = 0; k < 6; k++) begin
			case (k)
				0: dv = 64'd156;
				1: dv = 64'd110;
				2: dv = 64'd72;
				3: dv = 64'd42;
				4: dv = 64'd20;
				default: dv = 64'd6;
			endcase
			d = ((q * r) >> 30) / dv;
			r = (d >= ONE_Q30) ? 64'd0 : ONE_Q30 - d;
		end
		s = (u * r) >> 30;
		if (s > ONE_Q30)
			s = ONE_Q30;
		w = (s * s + (64'd1 << 43)) >> 44;
		if (w > 64'(UNITY))
			w = 64'(UNITY);
		return w[16:0];
	endfunction

	function automatic window_weight_t calc_window_weight(input window_req_t req);
		window_weight_t res;
		logic [63:0]    lo;
		logic [63:0]    hi;
		logic [63:0]    ctr;
		logic [63:0]    p;
		logic [63:0]    c;
		logic [63:0]    h;
		lo = 64'(req.span_lo);
		hi = 64'(req.span_hi);
		ctr = 64'(req.anchor);
		p = 64'(req.position);
		res = '0;
		if (ctr < lo || ctr > hi || hi <= lo || p >= hi - lo)
			return res;
		c = ctr - lo;
		h = hi - ctr;
		res.in_range = 1'b1;
		if (p < c) begin
			res.weight = req.flat_lo ? UNITY : sin_sq_q16(((p + 1) << FRAC) / (c + 1));
		end else begin
			res.weight = req.flat_hi ? UNITY : sin_sq_q16(((h - (p - c)) << FRAC) / h);
		end
		return res;
	endfunction

	function automatic window_req_t make_req(input int unsigned lo, input int unsigned hi,
			input int unsigned ctr, input bit el, input bit eh, input int unsigned p);
		window_req_t req;
		req.span_lo = lo[15:0];
		req.span_hi = hi[15:0];
		req.anchor = ctr[15:0];
		req.flat_lo = el;
		req.flat_hi = eh;
		req.position = p[15:0];
		return req;
	endfunction

	// mostly well-formed patches of mixed size, some noise and near misses
	function automatic window_req_t random_req();
		window_req_t req;
		int unsigned size;
		int unsigned lo;
		int unsigned ctr;
		int unsigned p;
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 12) begin
			req = window_req_t'({$urandom, $urandom, 2'($urandom)});
			return req;
		end
		case ($urandom_range(0, 9))
			0: size = $urandom_range(1, 65535);
			1, 2: size = $urandom_range(65, 4096);
			default: size = $urandom_range(1, 64);
		endcase
		lo = $urandom_range(0, 65535 - size);
		case ($urandom_range(0, 9))
			0: ctr = lo;
			1: ctr = lo + size;
			default: ctr = $urandom_range(lo, lo + size);
		endcase
		case ($urandom_range(0, 7))
			0: p = (ctr > lo) ? ctr - lo - 1 : 0;
			1: p = (ctr - lo < size) ? ctr - lo : 0;
			default: p = $urandom_range(0, size - 1);
		endcase
		if (sel < 20) begin
			if ($urandom_range(0, 1))
				p = size + $urandom_range(0, 2);
			else
				ctr = $urandom_range(0, 1) ? lo + size + 1 : lo - 1;
		end
		return make_req(lo, lo + size, ctr, 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), p);
	endfunction

	// driver: bursts of transactions with random gaps
	always @(negedge clk) begin
		window_req_t req;
		logic        nxt_valid;
		if (arst_n) begin
			nxt_valid = s_axis_tvalid;
			if (!s_axis_tvalid || in_taken) begin
				nxt_valid = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (window_reqs.size() > 0) begin
					req = window_reqs.pop_front();
					nxt_valid = 1'b1;
					s_axis_tdata <= {req.position, req.anchor, req.span_hi, req.span_lo};
					s_axis_tuser <= {req.flat_hi, req.flat_lo};
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 32);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
			end
			s_axis_tvalid <= nxt_valid;
		end
	end

	// receiver: stall pattern changes now and then, one long hold-off
	always @(negedge clk) begin
		logic rdy;
		if (arst_n) begin
			rx_cycle++;
			if (rx_cycle % 97 == 0)
				rx_mode = rx_mode_t'($urandom_range(0, 3));
			if (!hold_done && accepted_in >= 500) begin
				hold_done = 1'b1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else begin
				case (rx_mode)
					RX_OPEN:   rdy = 1'b1;
					RX_COIN:   rdy = 1'($urandom_range(0, 1));
					RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
					default:   rdy = (rx_cycle % 8 != 0);
				endcase
			end
			m_axis_tready <= rdy;
		end
	end

	// monitor: check the output transaction, then predict from the input transaction
	always @(posedge clk) begin
		window_weight_t exp_res;
		window_req_t    req;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_weights.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: result with nothing expected, tdata %0d tuser %0b",
							$time, m_axis_tdata, m_axis_tuser);
				end else begin
					exp_res = expected_weights.pop_front();
					if (m_axis_tdata !== {{PAD_W{1'b0}}, exp_res.weight}) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display("%0t: weight expected %0d, actual %0d", $time,
								exp_res.weight, m_axis_tdata);
					end
					if (m_axis_tuser !== exp_res.in_range) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display("%0t: in_range expected %0b, actual %0b", $time,
								exp_res.in_range, m_axis_tuser);
					end
				end
			end
			in_taken = s_axis_tvalid && s_axis_tready;
			if (in_taken) begin
				req.span_lo = s_axis_tdata[15:0];
				req.span_hi = s_axis_tdata[31:16];
				req.anchor = s_axis_tdata[47:32];
				req.position = s_axis_tdata[63:48];
				req.flat_lo = s_axis_tuser[0];
				req.flat_hi = s_axis_tuser[1];
				expected_weights.insert(expected_weights.size(), calc_window_weight(req));
				accepted_in++;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		accepted_in = 0;
		errors = 0;
		in_taken = 1'b0;
		gap_left = 0;
		burst_left = 8;
		rx_cycle = 0;
		hold_left = 0;
		hold_done = 1'b0;
		rx_mode = RX_OPEN;

		// full-width patch, both ends and the center
		window_reqs.insert(window_reqs.size(), make_req(0, 65535, 32767, 0, 0, 0));
		window_reqs.insert(window_reqs.size(), make_req(0, 65535, 32767, 0, 0, 65534));
		window_reqs.insert(window_reqs.size(), make_req(0, 65535, 32767, 0, 0, 65535));
		window_reqs.insert(window_reqs.size(), make_req(0, 65535, 32767, 0, 0, 32767));
		window_reqs.insert(window_reqs.size(), make_req(0, 65535, 32767, 0, 0, 32766));
		window_reqs.insert(window_reqs.size(), make_req(0, 65535, 0, 0, 0, 65534));
		window_reqs.insert(window_reqs.size(), make_req(0, 65535, 65535, 0, 0, 0));
		// empty and inverted patches
		window_reqs.insert(window_reqs.size(), make_req(65535, 65535, 65535, 0, 0, 0));
		window_reqs.insert(window_reqs.size(), make_req(100, 50, 60, 0, 0, 0));
		// center outside the bounds
		window_reqs.insert(window_reqs.size(), make_req(100, 200, 99, 0, 0, 5));
		window_reqs.insert(window_reqs.size(), make_req(100, 200, 201, 1, 1, 5));
		// center at the patch end, low ramp only
		window_reqs.insert(window_reqs.size(), make_req(10, 20, 20, 0, 1, 9));
		window_reqs.insert(window_reqs.size(), make_req(10, 20, 20, 0, 1, 0));
		// center at the patch start
		window_reqs.insert(window_reqs.size(), make_req(10, 20, 10, 1, 0, 0));
		// extend flags
		window_reqs.insert(window_reqs.size(), make_req(0, 16, 8, 1, 0, 3));
		window_reqs.insert(window_reqs.size(), make_req(0, 16, 8, 0, 1, 12));
		window_reqs.insert(window_reqs.size(), make_req(0, 16, 8, 1, 1, 7));
		window_reqs.insert(window_reqs.size(), make_req(0, 16, 8, 1, 1, 8));
		window_reqs.insert(window_reqs.size(), make_req(0, 16, 8, 0, 0, 16));
		// single-pixel patches
		window_reqs.insert(window_reqs.size(), make_req(65534, 65535, 65534, 0, 0, 0));
		window_reqs.insert(window_reqs.size(), make_req(65534, 65535, 65535, 0, 0, 0));
		window_reqs.insert(window_reqs.size(), make_req(0, 1, 0, 0, 0, 65535));
		// all ones and all zeros
		window_reqs.insert(window_reqs.size(), make_req(65535, 65535, 65535, 1, 1, 65535));
		window_reqs.insert(window_reqs.size(), make_req(0, 0, 0, 0, 0, 0));
		repeat (1250)
			window_reqs.insert(window_reqs.size(), random_req());
		n_items = window_reqs.size();

		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		while (accepted_in < n_items)
			@(posedge clk);
		while (expected_weights.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);

		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#3ms;
		$display("tb: failure");
		$finish;
	end

endmodule
